// File: rtl/imu_ca_pkg.sv
package imu_ca_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W = 5;
    localparam int CORD_W = 36;
    localparam int ANGLE_W = 32;
    localparam int QUOT_W = 22;
    // The increment divisor 131000000 is 64 * 2046875; the six low zero bits are dropped first.
    localparam logic [20:0] INC_DIV = 21'd2046875;
    // floor(2^31 / INC_DIV); an estimate built from it is never high and at most one low.
    localparam logic [20:0] INC_RECIP = 21'd1049;
    // Rounding half of the divisor, already divided by 64 and floored.
    localparam logic [30:0] INC_HALF = 31'd1023437;
    localparam logic signed [ANGLE_W-1:0] DEG180_Q16 = 32'sd11796480;
    localparam logic [15:0] WEIGHT_RESET = 16'd31785;
    localparam logic [16:0] WEIGHT_ONE = 17'd32768;

    localparam logic [7:0] REG_ACCEL_X_OFFSET = 8'd0;
    localparam logic [7:0] REG_ACCEL_Y_OFFSET = 8'd1;
    localparam logic [7:0] REG_ACCEL_Z_OFFSET = 8'd2;
    localparam logic [7:0] REG_GYRO_X_OFFSET  = 8'd3;
    localparam logic [7:0] REG_GYRO_Y_OFFSET  = 8'd4;
    localparam logic [7:0] REG_GYRO_Z_OFFSET  = 8'd5;
    localparam logic [7:0] REG_GYRO_WEIGHT    = 8'd6;

    // atan(2^-i) in Q15.16 degrees.
    function automatic logic signed [ANGLE_W-1:0] atan_q16(input logic [STEP_W-1:0] idx);
        logic signed [ANGLE_W-1:0] v;
        begin
            case (idx)
                5'd0:  v = 32'sd2949120;
                5'd1:  v = 32'sd1740967;
                5'd2:  v = 32'sd919879;
                5'd3:  v = 32'sd466945;
                5'd4:  v = 32'sd234379;
                5'd5:  v = 32'sd117304;
                5'd6:  v = 32'sd58666;
                5'd7:  v = 32'sd29335;
                5'd8:  v = 32'sd14668;
                5'd9:  v = 32'sd7334;
                5'd10: v = 32'sd3667;
                5'd11: v = 32'sd1833;
                5'd12: v = 32'sd917;
                5'd13: v = 32'sd458;
                5'd14: v = 32'sd229;
                5'd15: v = 32'sd115;
                5'd16: v = 32'sd57;
                5'd17: v = 32'sd29;
                5'd18: v = 32'sd14;
                5'd19: v = 32'sd7;
                5'd20: v = 32'sd4;
                5'd21: v = 32'sd2;
                5'd22: v = 32'sd1;
                default: v = 32'sd0;
            endcase
            return v;
        end
    endfunction

endpackage

// File: rtl/imu_complementary_attitude_top.sv
// Complementary roll/pitch/yaw filter for one six-axis IMU sample per input beat.
// Offsets are removed with 16-bit saturation, each gyro rate times elapsed_us is
// turned into a Q15.16 degree increment by reciprocal multiplication with a one-step
// correction, roll and pitch from the accelerometer come from one shared iterative
// CORDIC, and a single 17x32 multiplier blends the gyro and accelerometer angles.
// Per sample the sequencer accepts the beat; for each of the three gyro axes it
// runs a rate multiply, two reciprocal divide passes (estimate, remainder,
// correction) and an accumulate; then come two CORDIC runs, the roll and pitch
// blends and the output register load. s_tready is high only while the sequencer
// is idle; the result sits in an output register, so a new sample can be taken
// while the previous result still waits. Configuration writes are always accepted.
module imu_complementary_attitude_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, elapsed_us (16 bits each)
    input  logic [111:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // roll_deg, pitch_deg, yaw_deg (32 bits each)
    output logic [95:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [15:0]  cfg_data
);
    import imu_ca_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_QA, S_RA, S_CA, S_QB, S_RB, S_CB, S_ACC,
        S_CR_START, S_CR_WAIT, S_BL1, S_BL2, S_BL3, S_OUT
    } state_t;

    state_t state_reg;
    logic [1:0] axis_reg;

    logic signed [15:0] offset_reg [6];
    logic [15:0]        weight_reg;

    logic signed [15:0] corr_reg [6];
    logic [15:0]        dt_reg;
    logic [16:0]        w_reg;

    logic signed [ANGLE_W-1:0] est_reg  [3];
    logic signed [ANGLE_W-1:0] gsum_reg [3];
    logic signed [ANGLE_W-1:0] acc_ang_reg [2];

    logic [30:0]        div_num_reg;
    logic [10:0]        qe_reg;
    logic [10:0]        qa_reg;
    logic [21:0]        rem_reg;
    logic [QUOT_W-1:0]  quot_reg;
    logic               neg_reg;
    logic signed [49:0] acc_reg;

    logic               m_tvalid_reg;
    logic [95:0]        m_tdata_reg;

    // Offset removal with saturation.
    logic signed [15:0] corr [6];
    always_comb
    begin
        logic signed [16:0] d;
        for (int k = 0; k < 6; k++)
        begin
            d = {s_tdata[16*k+15], s_tdata[16*k +: 16]}
                - {offset_reg[k][15], offset_reg[k]};
            if (d > 17'sd32767)
                corr[k] = 16'sh7FFF;
            else if (d < -17'sd32768)
                corr[k] = 16'sh8000;
            else
                corr[k] = d[15:0];
        end
    end

    // Gyro increment datapath.
    logic signed [15:0] g_sel;
    logic [16:0]        g_mag;
    logic [32:0]        g_prod;
    logic signed [QUOT_W:0] inc;
    logic signed [33:0] gsum_wide;
    logic signed [ANGLE_W-1:0] gsum_sat;
    logic signed [ANGLE_W-1:0] est_sel;

    assign g_sel  = corr_reg[3'd3 + 3'(axis_reg)];
    assign g_mag  = g_sel[15] ? 17'(-{g_sel[15], g_sel}) : {1'b0, g_sel};
    assign g_prod = g_mag * {1'b0, dt_reg};
    assign inc    = neg_reg ? -$signed({1'b0, quot_reg}) : $signed({1'b0, quot_reg});
    assign est_sel = est_reg[axis_reg];
    assign gsum_wide = 34'(est_sel) + 34'(inc);
    always_comb
    begin
        if (gsum_wide > 34'sh0_7FFF_FFFF)
            gsum_sat = 32'sh7FFF_FFFF;
        else if (gsum_wide < -34'sh0_8000_0000)
            gsum_sat = 32'sh8000_0000;
        else
            gsum_sat = gsum_wide[31:0];
    end

    // The quotient is split as high * 1024 + low. Each pass estimates by the
    // reciprocal, forms the remainder, and adds one when the remainder is still
    // at least the divisor.
    logic        rm_est;
    logic [30:0] rm_a;
    logic [20:0] rm_b;
    logic [51:0] rm_p;
    logic [30:0] rm_diff;
    logic        rem_over;
    logic [21:0] rem_fix;
    logic [10:0] q_fix;

    assign rm_est   = (state_reg == S_QA) || (state_reg == S_QB);
    assign rm_a     = rm_est ? div_num_reg : {20'd0, qe_reg};
    assign rm_b     = rm_est ? INC_RECIP : INC_DIV;
    assign rm_p     = rm_a * rm_b;
    assign rm_diff  = div_num_reg - rm_p[30:0];
    assign rem_over = (rem_reg >= {1'b0, INC_DIV});
    assign rem_fix  = rem_over ? rem_reg - {1'b0, INC_DIV} : rem_reg;
    assign q_fix    = rem_over ? qe_reg + 11'd1 : qe_reg;

    // Shared CORDIC.
    logic                      cr_start;
    logic                      cr_done;
    logic signed [16:0]        cr_y;
    logic signed [16:0]        cr_x;
    logic signed [ANGLE_W-1:0] cr_angle;

    assign cr_start = (state_reg == S_CR_START);
    assign cr_x     = {corr_reg[2][15], corr_reg[2]};
    assign cr_y     = (axis_reg == 2'd0) ? {corr_reg[1][15], corr_reg[1]}
                                         : -{corr_reg[0][15], corr_reg[0]};

    imu_ca_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cr_start),
        .y_in  (cr_y),
        .x_in  (cr_x),
        .done  (cr_done),
        .angle (cr_angle)
    );

    // Shared blend multiplier.
    logic [16:0]               mul_a;
    logic signed [ANGLE_W-1:0] mul_b;
    logic signed [49:0]        mul_p;
    logic signed [49:0]        rnd;
    logic signed [34:0]        shr;
    logic signed [ANGLE_W-1:0] blend_sat;

    assign mul_a = (state_reg == S_BL1) ? w_reg : WEIGHT_ONE - w_reg;
    assign mul_b = (state_reg == S_BL1) ? gsum_reg[axis_reg] : acc_ang_reg[axis_reg[0]];
    assign mul_p = 50'($signed({1'b0, mul_a}) * mul_b);
    assign rnd   = acc_reg + 50'sd16384;
    assign shr   = 35'(rnd >>> 15);
    always_comb
    begin
        if (shr > 35'sh0_7FFF_FFFF)
            blend_sat = 32'sh7FFF_FFFF;
        else if (shr < -35'sh0_8000_0000)
            blend_sat = 32'sh8000_0000;
        else
            blend_sat = shr[31:0];
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 6; k++)
                offset_reg[k] <= '0;
            weight_reg <= WEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ACCEL_X_OFFSET: offset_reg[0] <= cfg_data;
                REG_ACCEL_Y_OFFSET: offset_reg[1] <= cfg_data;
                REG_ACCEL_Z_OFFSET: offset_reg[2] <= cfg_data;
                REG_GYRO_X_OFFSET:  offset_reg[3] <= cfg_data;
                REG_GYRO_Y_OFFSET:  offset_reg[4] <= cfg_data;
                REG_GYRO_Z_OFFSET:  offset_reg[5] <= cfg_data;
                REG_GYRO_WEIGHT:    weight_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            axis_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
                est_reg[k] <= '0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && state_reg != S_OUT)
                m_tvalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        for (int k = 0; k < 6; k++)
                            corr_reg[k] <= corr[k];
                        dt_reg    <= s_tdata[111:96];
                        w_reg     <= ({1'b0, weight_reg} > WEIGHT_ONE) ? WEIGHT_ONE
                                                                       : {1'b0, weight_reg};
                        axis_reg  <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    div_num_reg <= g_prod[30:0];
                    neg_reg     <= g_sel[15];
                    state_reg   <= S_QA;
                end
                S_QA:
                begin
                    qe_reg    <= rm_p[41:31];
                    state_reg <= S_RA;
                end
                S_RA:
                begin
                    rem_reg   <= rm_diff[21:0];
                    state_reg <= S_CA;
                end
                S_CA:
                begin
                    qa_reg      <= q_fix;
                    div_num_reg <= {rem_fix[20:0], 10'd0} + INC_HALF;
                    state_reg   <= S_QB;
                end
                S_QB:
                begin
                    qe_reg    <= rm_p[41:31];
                    state_reg <= S_RB;
                end
                S_RB:
                begin
                    rem_reg   <= rm_diff[21:0];
                    state_reg <= S_CB;
                end
                S_CB:
                begin
                    quot_reg  <= QUOT_W'({qa_reg, 10'd0}) + QUOT_W'(q_fix);
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    gsum_reg[axis_reg] <= gsum_sat;
                    if (axis_reg == 2'd2)
                    begin
                        axis_reg  <= 2'd0;
                        state_reg <= S_CR_START;
                    end
                    else
                    begin
                        axis_reg  <= axis_reg + 1'b1;
                        state_reg <= S_MUL;
                    end
                end
                S_CR_START:
                begin
                    state_reg <= S_CR_WAIT;
                end
                S_CR_WAIT:
                begin
                    if (cr_done)
                    begin
                        acc_ang_reg[axis_reg[0]] <= cr_angle;
                        if (axis_reg == 2'd0)
                        begin
                            axis_reg  <= 2'd1;
                            state_reg <= S_CR_START;
                        end
                        else
                        begin
                            axis_reg  <= 2'd0;
                            state_reg <= S_BL1;
                        end
                    end
                end
                S_BL1:
                begin
                    acc_reg   <= mul_p;
                    state_reg <= S_BL2;
                end
                S_BL2:
                begin
                    acc_reg   <= acc_reg + mul_p;
                    state_reg <= S_BL3;
                end
                S_BL3:
                begin
                    gsum_reg[axis_reg] <= blend_sat;
                    if (axis_reg == 2'd1)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        axis_reg  <= 2'd1;
                        state_reg <= S_BL1;
                    end
                end
                S_OUT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        for (int k = 0; k < 3; k++)
                            est_reg[k] <= gsum_reg[k];
                        m_tdata_reg  <= {gsum_reg[2], gsum_reg[1], gsum_reg[0]};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/imu_ca_cordic.sv
module imu_ca_cordic (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [16:0]                  y_in,
    input  logic signed [16:0]                  x_in,
    output logic                                done,
    output logic signed [imu_ca_pkg::ANGLE_W-1:0] angle
);
    import imu_ca_pkg::*;

    typedef enum logic [1:0] {C_IDLE, C_RUN, C_DONE} cstate_t;

    cstate_t                    state_reg;
    logic [STEP_W-1:0]          step_reg;
    logic signed [CORD_W-1:0]   x_reg;
    logic signed [CORD_W-1:0]   y_reg;
    logic signed [ANGLE_W-1:0]  z_reg;

    logic signed [CORD_W-1:0]   x_load;
    logic signed [CORD_W-1:0]   y_load;
    logic signed [CORD_W-1:0]   x_sh;
    logic signed [CORD_W-1:0]   y_sh;
    logic signed [ANGLE_W-1:0]  at;

    assign x_load = {{(CORD_W-33){x_in[16]}}, x_in, 16'd0};
    assign y_load = {{(CORD_W-33){y_in[16]}}, y_in, 16'd0};
    assign x_sh   = x_reg >>> step_reg;
    assign y_sh   = y_reg >>> step_reg;
    assign at     = atan_q16(step_reg);

    assign done  = (state_reg == C_DONE);
    assign angle = z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        step_reg <= '0;
                        if (x_in == 17'sd0 && y_in == 17'sd0)
                        begin
                            z_reg     <= '0;
                            state_reg <= C_DONE;
                        end
                        else
                        begin
                            // A vector in the left half-plane is turned by 180 degrees first.
                            if (x_in < 0)
                            begin
                                x_reg <= -x_load;
                                y_reg <= -y_load;
                                z_reg <= (y_in >= 0) ? DEG180_Q16 : -DEG180_Q16;
                            end
                            else
                            begin
                                x_reg <= x_load;
                                y_reg <= y_load;
                                z_reg <= '0;
                            end
                            state_reg <= C_RUN;
                        end
                    end
                end
                C_RUN:
                begin
                    if (y_reg >= 0)
                    begin
                        x_reg <= x_reg + y_sh;
                        y_reg <= y_reg - x_sh;
                        z_reg <= z_reg + at;
                    end
                    else
                    begin
                        x_reg <= x_reg - y_sh;
                        y_reg <= y_reg + x_sh;
                        z_reg <= z_reg - at;
                    end
                    if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                        state_reg <= C_DONE;
                    step_reg <= step_reg + 1'b1;
                end
                C_DONE:
                begin
                    state_reg <= C_IDLE;
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

import imu_ca_pkg::*;

typedef struct {
    logic signed [31:0] roll;
    logic signed [31:0] pitch;
    logic signed [31:0] yaw;
} attitude_t;

class attitude_scoreboard;
    logic signed [15:0] ofs [6];
    logic [15:0] weight;
    logic signed [31:0] roll_est, pitch_est, yaw_est;
    attitude_t pending [$];
    int errors;

    function new();
        foreach (ofs[i]) ofs[i] = 0;
        weight = WEIGHT_RESET;
        roll_est = 0;
        pitch_est = 0;
        yaw_est = 0;
        errors = 0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [15:0] val);
        if (idx < 6) ofs[idx] = val;
        else if (idx == REG_GYRO_WEIGHT) weight = val;
    endfunction

    static function longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    static function longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    static function longint increment(longint g, longint dt);
        longint mag;
        longint q;
        mag = (g < 0) ? -g : g;
        q = (mag * dt * 65536 + 65500000) / 131000000;
        return (g < 0) ? -q : q;
    endfunction

    static function longint angle_of(longint yin, longint xin);
        longint x, y, z, nx;
        if (xin == 0 && yin == 0) return 0;
        x = xin * 65536;
        y = yin * 65536;
        z = 0;
        if (x < 0) begin
            z = (y >= 0) ? longint'(DEG180_Q16) : -longint'(DEG180_Q16);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (y >= 0) begin
                nx = x + floor_shift(y, i);
                y = y - floor_shift(x, i);
                z += longint'(atan_q16(i[4:0]));
            end
            else begin
                nx = x - floor_shift(y, i);
                y = y + floor_shift(x, i);
                z -= longint'(atan_q16(i[4:0]));
            end
            x = nx;
        end
        return z;
    endfunction

    static function longint mix(longint g, longint a, longint w);
        return sat32(floor_shift(w * g + (32768 - w) * a + 16384, 15));
    endfunction

    function void note_sample(logic [111:0] d);
        longint c [6];
        longint dt, w, rg, pg, ra, pa, v;
        attitude_t r;
        for (int i = 0; i < 6; i++) begin
            v = longint'($signed(d[16*i +: 16])) - longint'(ofs[i]);
            c[i] = (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
        end
        dt = longint'(d[111:96]);
        w = (weight > 32768) ? 32768 : longint'(weight);
        rg = sat32(longint'(roll_est) + increment(c[3], dt));
        pg = sat32(longint'(pitch_est) + increment(c[4], dt));
        ra = angle_of(c[1], c[2]);
        pa = angle_of(-c[0], c[2]);
        yaw_est = 32'(sat32(longint'(yaw_est) + increment(c[5], dt)));
        roll_est = 32'(mix(rg, ra, w));
        pitch_est = 32'(mix(pg, pa, w));
        r.roll = roll_est;
        r.pitch = pitch_est;
        r.yaw = yaw_est;
        pending.push_back(r);
    endfunction

    function void check_result(logic [95:0] d);
        attitude_t e;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, d);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (d[31:0] !== e.roll) begin
            $display("%0t: roll expected %0d actual %0d", $time, e.roll, $signed(d[31:0]));
            errors++;
        end
        if (d[63:32] !== e.pitch) begin
            $display("%0t: pitch expected %0d actual %0d", $time, e.pitch,
                     $signed(d[63:32]));
            errors++;
        end
        if (d[95:64] !== e.yaw) begin
            $display("%0t: yaw expected %0d actual %0d", $time, e.yaw, $signed(d[95:64]));
            errors++;
        end
    endfunction
endclass

module testbench;
    logic clk = 0;
    logic rst_n = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [111:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [95:0] m_tdata;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [7:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    attitude_scoreboard board = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_off = 0;
    int quiet_cycles = 0;

    imu_complementary_attitude_top u_dut (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready) board.note_sample(s_tdata);
        if (rst_n && m_tvalid && m_tready) board.check_result(m_tdata);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        m_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (quiet_cycles > 20000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_reg(logic [7:0] idx, logic [15:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        board.write_reg(idx, val);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    // The block is busy for many cycles after each beat, so the idle cycle after
    // the handshake costs no throughput.
    task automatic send_sample(logic [111:0] d);
        while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        s_tvalid <= 1;
        s_tdata <= d;
        do @(posedge clk); while (!s_tready);
        s_tvalid <= 0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'(int'($urandom_range(600)) - 300);
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly random words with extreme, zero and small values mixed in; elapsed_us is usually 1000 to 20000.
    function automatic logic [111:0] random_sample();
        logic [111:0] d;
        for (int i = 0; i < 7; i++) d[16*i +: 16] = pick_word();
        if ($urandom_range(3) != 0) d[111:96] = 16'($urandom_range(1000, 20000));
        return d;
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) send_sample(random_sample());
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed samples at the reset configuration.
        send_sample('0);
        send_sample({16'hffff, {6{16'h7fff}}});
        send_sample({16'hffff, {6{16'h8000}}});
        send_sample({16'd1000, 16'd0, 16'd0, 16'd0, 16'd16384, 16'd0, 16'd0});
        send_sample({16'd0, 16'd500, 16'd500, 16'd500, 16'h8000, 16'd100, 16'd0});
        send_sample({16'd5000, 16'h7fff, 16'h8000, 16'h0001, 16'h8000, 16'h7fff, 16'h8000});
        send_sample({16'd5000, 16'h0000, 16'h0000, 16'h0000, 16'hc000, 16'h0000, 16'h4000});
        send_sample({16'hffff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h0000, 16'h0000, 16'h0000});
        drain();

        // Extreme offsets push the corrected words into saturation.
        for (int i = 0; i < 6; i++) write_reg(i[7:0], (i % 2) ? 16'h8000 : 16'h7fff);
        write_reg(REG_GYRO_WEIGHT, 16'hffff);
        write_reg(8'd9, 16'h1234);
        send_sample({16'hffff, {6{16'h7fff}}});
        send_sample({16'hffff, {6{16'h8000}}});
        send_sample({16'd300, {6{16'h0000}}});
        drain();
        write_reg(REG_GYRO_WEIGHT, 16'd0);
        send_sample({16'd300, 16'd10, 16'd20, 16'd30, 16'd40, 16'd50, 16'd60});
        drain();

        send_idle_pct = 32;
        recv_idle_pct = 67;
        for (int i = 0; i < 6; i++) write_reg(i[7:0], 16'(int'($urandom_range(400)) - 200));
        write_reg(REG_GYRO_WEIGHT, WEIGHT_RESET);
        random_phase(500);
        drain();

        send_idle_pct = 67;
        recv_idle_pct = 32;
        for (int i = 0; i < 6; i++) write_reg(i[7:0], 16'($urandom));
        write_reg(REG_GYRO_WEIGHT, 16'd32768);
        random_phase(500);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 6; i++) write_reg(i[7:0], 16'd0);
        write_reg(REG_GYRO_WEIGHT, 16'($urandom_range(32768)));
        fork
            begin
                hold_off = 1;
                repeat (1500) @(posedge clk);
                hold_off = 0;
            end
            random_phase(20);
        join
        random_phase(700);
        drain();

        if (board.errors == 0 && board.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// File: imu_complementary_attitude_top.f
rtl/imu_ca_pkg.sv
rtl/imu_ca_cordic.sv
rtl/imu_complementary_attitude_top.sv
test/testbench.sv
